FILE: rtl/sgbd_pkg.sv
// Shared types and constants of the separable Gaussian blur / DoG block.
package sgbd_pkg;

   // configuration port geometry
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RADIUS       = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_COEF_NEAR    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_COEF_FAR     = 3'd4;

   // register field widths
   localparam int GEOM_BITS      = 11;
   localparam int RADIUS_BITS    = 4;
   localparam int COEF_NEAR_BITS = 64;
   localparam int COEF_FAR_BITS  = 24;
   localparam int COEF_BITS      = 8;
   localparam int NEAR_TAPS      = 8;
   localparam int FAR_TAPS       = 3;
   localparam int COEF_SLOTS     = 16;

   // Q0.8 rounding
   localparam int ROUND_HALF = 128;
   localparam int FRAC_SHIFT = 8;

   // commands from the sequencer to the datapath
   typedef struct packed {
      logic take;       // accept the request word
      logic col_clear;  // start a new output: clear column sum and row index
      logic row_start;  // clear row sum, load row weight
      logic tap_sel;    // clamp row/column of the current tap, load tap weight
      logic tap_addr;   // form memory address of the tap
      logic rd;         // read the pixel memory
      logic tap_mul;    // pixel times tap weight
      logic tap_acc;    // add into row sum, advance tap
      logic row_rnd;    // round and saturate the row sum
      logic row_mul;    // row result times row weight
      logic col_acc;    // add into column sum, advance row
      logic ctr_addr;   // form address of the center pixel
      logic finish;     // round column sum, form difference
      logic emit;       // load the result register
   } cmd_type;

   // status back to the sequencer
   typedef struct packed {
      logic emit_req;   // the offered word produces a result
      logic tap_last;   // last tap of the row
      logic row_last;   // last row of the window
      logic out_free;   // result register can take a word
   } status_type;

endpackage

FILE: rtl/sgbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sgbd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/sgbd_ctrl.sv
// Sequencer that walks the 2D kernel window one tap at a time.
module sgbd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  sgbd_pkg::status_type status,
   output sgbd_pkg::cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_ROW   = 4'd1;
   localparam logic [3:0] ST_SEL   = 4'd2;
   localparam logic [3:0] ST_ADDR  = 4'd3;
   localparam logic [3:0] ST_READ  = 4'd4;
   localparam logic [3:0] ST_MUL   = 4'd5;
   localparam logic [3:0] ST_ACC   = 4'd6;
   localparam logic [3:0] ST_RND   = 4'd7;
   localparam logic [3:0] ST_RMUL  = 4'd8;
   localparam logic [3:0] ST_CACC  = 4'd9;
   localparam logic [3:0] ST_CADDR = 4'd10;
   localparam logic [3:0] ST_CREAD = 4'd11;
   localparam logic [3:0] ST_CFIN  = 4'd12;
   localparam logic [3:0] ST_EMIT  = 4'd13;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.take = req_valid;
            if (req_valid && status.emit_req) begin
               cmd.col_clear = 1'b1;
               state_in      = ST_ROW;
            end
         end
         ST_ROW: begin
            cmd.row_start = 1'b1;
            state_in      = ST_SEL;
         end
         ST_SEL: begin
            cmd.tap_sel = 1'b1;
            state_in    = ST_ADDR;
         end
         ST_ADDR: begin
            cmd.tap_addr = 1'b1;
            state_in     = ST_READ;
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.tap_mul = 1'b1;
            state_in    = ST_ACC;
         end
         ST_ACC: begin
            cmd.tap_acc = 1'b1;
            state_in    = status.tap_last ? ST_RND : ST_SEL;
         end
         ST_RND: begin
            cmd.row_rnd = 1'b1;
            state_in    = ST_RMUL;
         end
         ST_RMUL: begin
            cmd.row_mul = 1'b1;
            state_in    = ST_CACC;
         end
         ST_CACC: begin
            cmd.col_acc = 1'b1;
            state_in    = status.row_last ? ST_CADDR : ST_ROW;
         end
         ST_CADDR: begin
            cmd.ctr_addr = 1'b1;
            state_in     = ST_CREAD;
         end
         ST_CREAD: begin
            cmd.rd   = 1'b1;
            state_in = ST_CFIN;
         end
         ST_CFIN: begin
            cmd.finish = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

FILE: rtl/sgbd_datapath.sv
// Datapath: configuration, frame counters, pixel store, MAC and result register.
module sgbd_datapath #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int MAX_RADIUS = 10,
   parameter int PIXEL_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wen,
   input  logic [sgbd_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [sgbd_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   input  logic [PIXEL_BITS-1:0]                  req_pixel,
   input  logic                                   req_drain,
   input  sgbd_pkg::cmd_type                      cmd,
   output sgbd_pkg::status_type                   status,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [PIXEL_BITS-1:0]                  rsp_blurred,
   output logic signed [PIXEL_BITS:0]             rsp_difference,
   output logic                                   rsp_frame_end
);

   localparam int XW   = $clog2(MAX_WIDTH);
   localparam int WW   = $clog2(MAX_WIDTH + 1);
   localparam int HW   = $clog2(MAX_HEIGHT);
   localparam int HHW  = $clog2(MAX_HEIGHT + 1);
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW   = $clog2(DEPTH);
   localparam int TW   = $clog2(DEPTH + 1);
   localparam int RW   = $clog2(MAX_RADIUS + 1);
   localparam int IW   = $clog2(2 * MAX_RADIUS + 1);
   localparam int TAPW = $clog2(2 * MAX_RADIUS + 2);
   localparam int PW   = PIXEL_BITS + sgbd_pkg::COEF_BITS;
   localparam int ACW  = PW + TAPW + 1;
   localparam int SYW  = HW + 2;
   localparam int SXW  = XW + 2;
   localparam int MW   = HW + WW;

   // round half up, drop the Q0.8 fraction and saturate
   function automatic logic [PIXEL_BITS-1:0] round_sat(input logic [ACW-1:0] acc);
      logic [ACW-1:0] v;
      v = (acc + ACW'(sgbd_pkg::ROUND_HALF)) >> sgbd_pkg::FRAC_SHIFT;
      if (v > ACW'({PIXEL_BITS{1'b1}})) begin
         return {PIXEL_BITS{1'b1}};
      end
      return PIXEL_BITS'(v);
   endfunction

   // configuration registers
   logic [sgbd_pkg::GEOM_BITS-1:0]      width_ff, height_ff;
   logic [sgbd_pkg::RADIUS_BITS-1:0]    radius_ff;
   logic [sgbd_pkg::COEF_NEAR_BITS-1:0] coef_near_ff;
   logic [sgbd_pkg::COEF_FAR_BITS-1:0]  coef_far_ff;
   logic                                cfg_hit;

   // counters and loop indexes
   logic [TW-1:0] in_cnt_ff, out_cnt_ff;
   logic [XW-1:0] out_x_ff;
   logic [HW-1:0] out_y_ff;
   logic [IW-1:0] ix_ff, iy_ff;

   // tap pipeline registers
   logic [HW-1:0]                    row_sel_ff;
   logic [XW-1:0]                    col_sel_ff;
   logic [sgbd_pkg::COEF_BITS-1:0]   wgt_x_ff, wgt_y_ff;
   logic [AW-1:0]                    addr_ff;
   logic [PW-1:0]                    prod_ff;
   logic [ACW-1:0]                   row_acc_ff, col_acc_ff;
   logic [PIXEL_BITS-1:0]            row_val_ff, blur_ff;
   logic signed [PIXEL_BITS:0]       diff_ff;

   // result register
   logic                             rsp_valid_ff;
   logic [PIXEL_BITS-1:0]            rsp_blurred_ff;
   logic signed [PIXEL_BITS:0]       rsp_difference_ff;
   logic                             rsp_frame_end_ff;

   // effective geometry
   logic [WW-1:0]  w_eff;
   logic [HHW-1:0] h_eff;
   logic [RW-1:0]  r_eff;
   logic [TW-1:0]  total, lag;
   logic           full;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = WW'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = HHW'(1);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         h_eff = HHW'(MAX_HEIGHT);
      end else begin
         h_eff = HHW'(height_ff);
      end
      if (radius_ff == '0) begin
         r_eff = RW'(1);
      end else if (32'(radius_ff) > 32'(MAX_RADIUS)) begin
         r_eff = RW'(MAX_RADIUS);
      end else begin
         r_eff = RW'(radius_ff);
      end
   end

   assign total = TW'(32'(w_eff) * 32'(h_eff));
   assign lag   = TW'(32'(r_eff) * 32'(w_eff) + 32'(r_eff));
   assign full  = (in_cnt_ff >= total);

   // status: whether the offered word produces a result, loop ends, output room
   always_comb begin
      status.tap_last = (ix_ff == IW'({r_eff, 1'b0}));
      status.row_last = (iy_ff == IW'({r_eff, 1'b0}));
      status.out_free = !rsp_valid_ff || !rsp_stall;
      if (req_drain) begin
         status.emit_req = full && (out_cnt_ff < total);
      end else if (full) begin
         status.emit_req = (lag == '0);
      end else begin
         status.emit_req = (in_cnt_ff >= lag) && (out_cnt_ff < total);
      end
   end

   // coefficient table by offset, zero past the far group
   logic [sgbd_pkg::COEF_BITS-1:0] coef_tab [sgbd_pkg::COEF_SLOTS];
   always_comb begin
      for (int k = 0; k < sgbd_pkg::COEF_SLOTS; k++) begin
         if (k < sgbd_pkg::NEAR_TAPS) begin
            coef_tab[k] = coef_near_ff[k*sgbd_pkg::COEF_BITS +: sgbd_pkg::COEF_BITS];
         end else if (k < sgbd_pkg::NEAR_TAPS + sgbd_pkg::FAR_TAPS) begin
            coef_tab[k] = coef_far_ff[(k-sgbd_pkg::NEAR_TAPS)*sgbd_pkg::COEF_BITS +:
                                      sgbd_pkg::COEF_BITS];
         end else begin
            coef_tab[k] = '0;
         end
      end
   end

   // offset of the current row or tap from the center
   logic [IW-1:0]              off_idx;
   logic signed [IW:0]         off_d;
   logic [IW-1:0]              off_abs;
   logic [sgbd_pkg::COEF_BITS-1:0] wgt_sel;
   always_comb begin
      off_idx = cmd.row_start ? iy_ff : ix_ff;
      off_d   = $signed((IW+1)'(off_idx)) - $signed((IW+1)'(r_eff));
      off_abs = off_d[IW] ? IW'(-off_d) : IW'(off_d);
      wgt_sel = coef_tab[4'(off_abs)];
   end

   // clamp the tap position to the frame
   logic signed [SYW-1:0] sy;
   logic signed [SXW-1:0] sx;
   logic [HW-1:0]         row_clamp;
   logic [XW-1:0]         col_clamp;
   always_comb begin
      sy = $signed(SYW'(out_y_ff)) + $signed(SYW'(iy_ff)) - $signed(SYW'(r_eff));
      sx = $signed(SXW'(out_x_ff)) + $signed(SXW'(ix_ff)) - $signed(SXW'(r_eff));
      if (sy < 0) begin
         row_clamp = '0;
      end else if (sy >= $signed(SYW'(h_eff))) begin
         row_clamp = HW'(h_eff - HHW'(1));
      end else begin
         row_clamp = sy[HW-1:0];
      end
      if (sx < 0) begin
         col_clamp = '0;
      end else if (sx >= $signed(SXW'(w_eff))) begin
         col_clamp = XW'(w_eff - WW'(1));
      end else begin
         col_clamp = sx[XW-1:0];
      end
   end

   // address multiplier shared by taps and the center pixel
   logic [MW-1:0] mul_row;
   logic [AW-1:0] addr_in;
   always_comb begin
      mul_row = (cmd.ctr_addr ? MW'(out_y_ff) : MW'(row_sel_ff)) * MW'(w_eff);
      addr_in = AW'(mul_row) + (cmd.ctr_addr ? AW'(out_x_ff) : AW'(col_sel_ff));
   end

   // pixel store
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [PIXEL_BITS-1:0] rd_data;
   assign wr_en   = cmd.take && !req_drain;
   assign wr_addr = full ? '0 : AW'(in_cnt_ff);

   sgbd_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_pixel),
      .rd_en   (cmd.rd),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign cfg_hit = csr_wen && (csr_index <= sgbd_pkg::REG_COEF_FAR);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= sgbd_pkg::GEOM_BITS'(1024);
         height_ff    <= sgbd_pkg::GEOM_BITS'(1024);
         radius_ff    <= sgbd_pkg::RADIUS_BITS'(5);
         coef_near_ff <= '0;
         coef_far_ff  <= '0;
      end else if (csr_wen) begin
         unique case (csr_index)
            sgbd_pkg::REG_FRAME_WIDTH:  width_ff  <= csr_wdata[sgbd_pkg::GEOM_BITS-1:0];
            sgbd_pkg::REG_FRAME_HEIGHT: height_ff <= csr_wdata[sgbd_pkg::GEOM_BITS-1:0];
            sgbd_pkg::REG_RADIUS:       radius_ff <= csr_wdata[sgbd_pkg::RADIUS_BITS-1:0];
            sgbd_pkg::REG_COEF_NEAR:
               coef_near_ff <= csr_wdata[sgbd_pkg::COEF_NEAR_BITS-1:0];
            sgbd_pkg::REG_COEF_FAR:
               coef_far_ff <= csr_wdata[sgbd_pkg::COEF_FAR_BITS-1:0];
            default: ;
         endcase
      end
   end

   // frame counters: restart on config, new frame, or after the last result
   logic last_out;
   assign last_out = ((out_cnt_ff + TW'(1)) >= total);

   always_ff @(posedge clock) begin
      if (reset || cfg_hit) begin
         in_cnt_ff  <= '0;
         out_cnt_ff <= '0;
         out_x_ff   <= '0;
         out_y_ff   <= '0;
      end else if (wr_en) begin
         if (full) begin
            in_cnt_ff  <= TW'(1);
            out_cnt_ff <= '0;
            out_x_ff   <= '0;
            out_y_ff   <= '0;
         end else begin
            in_cnt_ff <= in_cnt_ff + TW'(1);
         end
      end else if (cmd.emit) begin
         if (last_out) begin
            in_cnt_ff  <= '0;
            out_cnt_ff <= '0;
            out_x_ff   <= '0;
            out_y_ff   <= '0;
         end else begin
            out_cnt_ff <= out_cnt_ff + TW'(1);
            if (WW'(out_x_ff) + WW'(1) == w_eff) begin
               out_x_ff <= '0;
               out_y_ff <= out_y_ff + HW'(1);
            end else begin
               out_x_ff <= out_x_ff + XW'(1);
            end
         end
      end
   end

   // window walk and multiply-accumulate
   always_ff @(posedge clock) begin
      if (cmd.col_clear) begin
         col_acc_ff <= '0;
         iy_ff      <= '0;
      end
      if (cmd.row_start) begin
         row_acc_ff <= '0;
         ix_ff      <= '0;
         wgt_y_ff   <= wgt_sel;
      end
      if (cmd.tap_sel) begin
         wgt_x_ff   <= wgt_sel;
         row_sel_ff <= row_clamp;
         col_sel_ff <= col_clamp;
      end
      if (cmd.tap_addr || cmd.ctr_addr) begin
         addr_ff <= addr_in;
      end
      if (cmd.tap_mul) begin
         prod_ff <= PW'(rd_data) * PW'(wgt_x_ff);
      end
      if (cmd.tap_acc) begin
         row_acc_ff <= row_acc_ff + ACW'(prod_ff);
         ix_ff      <= ix_ff + IW'(1);
      end
      if (cmd.row_rnd) begin
         row_val_ff <= round_sat(row_acc_ff);
      end
      if (cmd.row_mul) begin
         prod_ff <= PW'(row_val_ff) * PW'(wgt_y_ff);
      end
      if (cmd.col_acc) begin
         col_acc_ff <= col_acc_ff + ACW'(prod_ff);
         iy_ff      <= iy_ff + IW'(1);
      end
      if (cmd.finish) begin
         blur_ff <= round_sat(col_acc_ff);
         diff_ff <= $signed({1'b0, round_sat(col_acc_ff)}) - $signed({1'b0, rd_data});
      end
   end

   // result register: hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_blurred_ff    <= blur_ff;
         rsp_difference_ff <= diff_ff;
         rsp_frame_end_ff  <= last_out;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_blurred    = rsp_blurred_ff;
   assign rsp_difference = rsp_difference_ff;
   assign rsp_frame_end  = rsp_frame_end_ff;

endmodule

FILE: rtl/separable_gaussian_blur_dog_top.sv
// A word that yields no result is taken while idle; a word that yields a result occupies
// the block while it walks the T x T window (T = 2*radius+1) until its result is emitted.
// Throughput: one word at a time; the rate is set by the single read port of the pixel
// store, visited once per kernel tap plus once for the center pixel.
// Reset: synchronous, active high; restores register defaults, clears the frame counters,
// the sequencer and the result valid. The pixel store is not cleared.
module separable_gaussian_blur_dog_top #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int MAX_RADIUS = 10,
   parameter int PIXEL_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wen,
   input  logic [sgbd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sgbd_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [PIXEL_BITS-1:0]               req_pixel,
   input  logic                                req_drain,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [PIXEL_BITS-1:0]               rsp_blurred,
   output logic signed [PIXEL_BITS:0]          rsp_difference,
   output logic                                rsp_frame_end
);

   sgbd_pkg::cmd_type    cmd;
   sgbd_pkg::status_type status;

   sgbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sgbd_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_RADIUS (MAX_RADIUS),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_wen        (csr_wen),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_pixel      (req_pixel),
      .req_drain      (req_drain),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_blurred    (rsp_blurred),
      .rsp_difference (rsp_difference),
      .rsp_frame_end  (rsp_frame_end)
   );

endmodule

FILE: rtl/sgbd_checker.sv
// Port-level checks for the blur / DoG block, bound to the top level.
module sgbd_checker #(
   parameter int PIXEL_BITS = 16
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [PIXEL_BITS-1:0]      rsp_blurred,
   input logic signed [PIXEL_BITS:0] rsp_difference,
   input logic                       rsp_frame_end
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_blurred)
         && $stable(rsp_difference) && $stable(rsp_frame_end)))
      else $error("result word changed while stalled");

   // a new result only appears after the block has been busy filtering
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a filtering pass");

   // the input pixel is never negative, so the difference never exceeds the blur
   a_diff_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_difference <= $signed({1'b0, rsp_blurred})))
      else $error("difference larger than blurred pixel");

   // reset leaves the result channel empty and the input open
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("result or stall left over from reset");

endmodule

bind separable_gaussian_blur_dog_top sgbd_checker #(
   .PIXEL_BITS (PIXEL_BITS)
) u_sgbd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_blurred    (rsp_blurred),
   .rsp_difference (rsp_difference),
   .rsp_frame_end  (rsp_frame_end)
);
